// File: hw/rtl/kwc_pkg.sv
// shared constants, keyword table and types for the keyword occurrence counter
`timescale 1ns / 1ps
`default_nettype none
package kwc_pkg;

    localparam int MAX_WORD       = 100;
    localparam int COUNT_BITS     = 32;
    localparam int OUT_COUNT_BITS = 32;
    localparam int NUM_KEYS       = 11;
    localparam int PREFIX_LEN     = 8;
    localparam int KEY_BITS       = 4;
    localparam int LEN_BITS       = $clog2(MAX_WORD);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int IN_DATA_BITS   = 8;
    localparam int OUT_DATA_BITS  = 40;

    // keyword text, first character in the lowest byte, zero padded
    localparam logic [8*PREFIX_LEN-1:0] KW_TEXT [NUM_KEYS] = '{
        64'h0000_0000_6F74_7561,  // auto
        64'h0000_006B_6165_7262,  // break
        64'h0000_0000_6573_6163,  // case
        64'h0000_0000_7261_6863,  // char
        64'h0000_0074_736E_6F63,  // const
        64'h6575_6E69_746E_6F63,  // continue
        64'h0074_6C75_6166_6564,  // default
        64'h6465_6E67_6973_6E75,  // unsigned
        64'h0000_0000_6469_6F76,  // void
        64'h656C_6974_616C_6F76,  // volatile
        64'h0000_0065_6C69_6877   // while
    };

    localparam logic [KEY_BITS-1:0] KW_LEN [NUM_KEYS] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd8, 4'd4, 4'd8, 4'd5
    };

    localparam logic [KEY_BITS-1:0] LAST_KEY = KEY_BITS'(NUM_KEYS - 1);

    // request passed from the tokenizer to the counter side
    typedef struct packed {
        logic                has_match;
        logic [KEY_BITS-1:0] key;
        logic                report;
    } t_cmd;

endpackage
`default_nettype wire

// File: hw/rtl/kwc_front.sv
// tokenizer: splits the character stream into words and matches them to keywords
`timescale 1ns / 1ps
`default_nettype none
module kwc_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [7:0]                       i_char,
    input  wire logic                             i_end,
    input  wire logic                             i_queue_full,
    output logic                                  o_ready,
    output logic                                  o_push,
    output kwc_pkg::t_cmd                         o_cmd
);

    logic [8*kwc_pkg::PREFIX_LEN-1:0] r_prefix, n_prefix;
    logic [kwc_pkg::LEN_BITS-1:0]     r_len, n_len;
    logic                             r_inside, n_inside;

    logic                             w_accept;
    logic                             w_letter;
    logic                             w_digit;
    logic                             w_add;
    logic [kwc_pkg::LEN_BITS-1:0]     w_add_len;
    logic [8*kwc_pkg::PREFIX_LEN-1:0] w_add_prefix;
    logic                             w_finish;
    logic                             w_sel_next;
    logic [8*kwc_pkg::PREFIX_LEN-1:0] w_cmp_word;
    logic [kwc_pkg::LEN_BITS-1:0]     w_cmp_len;
    logic                             w_found;
    logic [kwc_pkg::KEY_BITS-1:0]     w_key;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_letter = (i_char >= 8'h41 && i_char <= 8'h5A) || (i_char >= 8'h61 && i_char <= 8'h7A);
    assign w_digit  = (i_char >= 8'h30 && i_char <= 8'h39);
    assign w_add    = !i_end && (w_letter || (r_inside && w_digit));

    // word with the current character appended
    always_comb begin
        w_add_len    = r_inside ? r_len + 1'b1 : kwc_pkg::LEN_BITS'(1);
        w_add_prefix = r_inside ? r_prefix : '0;
        for (int b = 0; b < kwc_pkg::PREFIX_LEN; b++) begin
            if (r_inside && r_len == kwc_pkg::LEN_BITS'(b)) begin
                w_add_prefix[8*b +: 8] = i_char;
            end
        end
        if (!r_inside) begin
            w_add_prefix[7:0] = i_char;
        end
    end

    // word closes at end of text, at a delimiter or when it reaches MAX_WORD - 1 characters
    always_comb begin
        w_sel_next = w_add;
        if (i_end) begin
            w_finish = r_inside;
        end else if (w_add) begin
            w_finish = (w_add_len == kwc_pkg::LEN_BITS'(kwc_pkg::MAX_WORD - 1));
        end else begin
            w_finish = r_inside;
        end
        w_cmp_word = w_sel_next ? w_add_prefix : r_prefix;
        w_cmp_len  = w_sel_next ? w_add_len : r_len;
    end

    // all keywords compared at once, at most one can hit
    always_comb begin
        w_found = 1'b0;
        w_key   = '0;
        for (int k = 0; k < kwc_pkg::NUM_KEYS; k++) begin
            if (w_cmp_word == kwc_pkg::KW_TEXT[k]
                && w_cmp_len == kwc_pkg::LEN_BITS'(kwc_pkg::KW_LEN[k])) begin
                w_found = 1'b1;
                w_key   = kwc_pkg::KEY_BITS'(k);
            end
        end
        w_found = w_found && w_finish;
    end

    always_comb begin
        n_prefix = r_prefix;
        n_len    = r_len;
        n_inside = r_inside;
        if (w_accept) begin
            if (w_finish) begin
                n_prefix = '0;
                n_len    = '0;
                n_inside = 1'b0;
            end else if (w_add) begin
                n_prefix = w_add_prefix;
                n_len    = w_add_len;
                n_inside = 1'b1;
            end
        end
    end

    assign o_push          = w_accept && (i_end || w_found);
    assign o_cmd.has_match = w_found;
    assign o_cmd.key       = w_key;
    assign o_cmd.report    = i_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_len    <= '0;
            r_inside <= 1'b0;
        end else begin
            r_prefix <= n_prefix;
            r_len    <= n_len;
            r_inside <= n_inside;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/kwc_queue.sv
// short request queue between the tokenizer and the counter side
`timescale 1ns / 1ps
`default_nettype none
module kwc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire kwc_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output kwc_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    kwc_pkg::t_cmd                 r_mem [kwc_pkg::QUEUE_DEPTH];
    logic [kwc_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [kwc_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [kwc_pkg::QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (kwc_pkg::QPTR_BITS + 1)'(kwc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/kwc_back.sv
// counter side: keeps the saturating tallies and streams the report
`timescale 1ns / 1ps
`default_nettype none
module kwc_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire kwc_pkg::t_cmd                        i_cmd,
    input  wire logic                                 i_empty,
    output logic                                      o_pop,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [kwc_pkg::KEY_BITS-1:0]              o_key,
    output logic [kwc_pkg::OUT_COUNT_BITS-1:0]        o_count,
    output logic                                      o_last
);

    typedef enum logic {ST_IDLE, ST_REPORT} t_state;

    t_state                          r_state;
    logic [kwc_pkg::KEY_BITS-1:0]    r_idx;
    logic [kwc_pkg::COUNT_BITS-1:0]  r_tally [kwc_pkg::NUM_KEYS];
    logic                            w_free;
    logic [63:0]                     w_ext;
    logic [kwc_pkg::OUT_COUNT_BITS-1:0] w_clamped;

    assign o_pop  = (r_state == ST_IDLE) && !i_empty;
    assign w_free = !o_valid || i_ready;

    // counts wider than the output field report as all ones
    assign w_ext     = 64'(r_tally[r_idx]);
    assign w_clamped = (|w_ext[63:kwc_pkg::OUT_COUNT_BITS]) ? '1
                                                            : w_ext[kwc_pkg::OUT_COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            o_valid <= 1'b0;
            o_key   <= '0;
            o_count <= '0;
            o_last  <= 1'b0;
            for (int k = 0; k < kwc_pkg::NUM_KEYS; k++) begin
                r_tally[k] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                    end
                    if (!i_empty) begin
                        for (int k = 0; k < kwc_pkg::NUM_KEYS; k++) begin
                            if (i_cmd.has_match && i_cmd.key == kwc_pkg::KEY_BITS'(k)
                                && !(&r_tally[k])) begin
                                r_tally[k] <= r_tally[k] + 1'b1;
                            end
                        end
                        if (i_cmd.report) begin
                            r_state <= ST_REPORT;
                            r_idx   <= '0;
                        end
                    end
                end
                ST_REPORT: begin
                    if (w_free) begin
                        o_valid <= 1'b1;
                        o_key   <= r_idx;
                        o_count <= w_clamped;
                        o_last  <= (r_idx == kwc_pkg::LAST_KEY);
                        for (int k = 0; k < kwc_pkg::NUM_KEYS; k++) begin
                            if (r_idx == kwc_pkg::KEY_BITS'(k)) begin
                                r_tally[k] <= '0;
                            end
                        end
                        if (r_idx == kwc_pkg::LAST_KEY) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/keyword_occurrence_counter.sv
// top level of the keyword occurrence counter
// Usage:
//   Slave stream: one ASCII character per request in s_axis_tdata; s_axis_tuser
//   set marks end of text. Words (a letter, then letters and digits) that equal
//   one of eleven C keywords bump that keyword's saturating counter.
//   Master stream: on end of text, eleven requests in table order (auto .. while),
//   each with the keyword index and its count; tlast on the last one. Counters
//   then clear and the next character starts a fresh word.
// Flow:
//   Characters are taken one per cycle while the four-entry request queue has
//   room. A keyword hit or end of text is written into the queue and taken at
//   its head by the counter side once that side is idle; end of text starts the
//   report from the counter side, keyword by keyword in table order.
// Reset: synchronous, active low; clears the open word, queue and all counters.
// Stalls: a stalled receiver holds the report; the queue fills and s_axis_tready
//   drops only when four hits or reports are waiting behind it.
`timescale 1ns / 1ps
`default_nettype none
module keyword_occurrence_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_char
    input  wire logic        s_axis_tuser,   // [0] end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [3:0] keyword_index, [35:4] keyword_count, zeros
    output logic             m_axis_tlast    // last_of_report
);

    kwc_pkg::t_cmd                       w_push_cmd;
    kwc_pkg::t_cmd                       w_head_cmd;
    logic                                w_push;
    logic                                w_pop;
    logic                                w_full;
    logic                                w_empty;
    logic [kwc_pkg::KEY_BITS-1:0]        w_key;
    logic [kwc_pkg::OUT_COUNT_BITS-1:0]  w_count;

    kwc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_char       (s_axis_tdata),
        .i_end        (s_axis_tuser),
        .i_queue_full (w_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    kwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    kwc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_key   (w_key),
        .o_count (w_count),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_count, w_key};

endmodule
`default_nettype wire

// File: hw/rtl/kwc_checker.sv
// port-level checks for the keyword occurrence counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module kwc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // last mark only on the final keyword, and only there
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[3:0] == 4'd10)))
        else $error("last mark out of place");

    // report runs through the table without gaps
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1)
        else $error("report sequence broken");

    // report never starts mid table and padding is clear at its start
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && $past(m_axis_tlast || !m_axis_tvalid) |->
            m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[39:36] == 4'd0)
        else $error("report start wrong");

endmodule

bind keyword_occurrence_counter kwc_checker u_kwc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
